@@ hdl/mcoc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcoc_pkg
// Shared types and constants for the matrix chain order cost core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcoc_pkg;

    localparam int COST_W = 48;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_TRUNC = 2'd2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [2:0] {
        S_LOAD,
        S_HDR,
        S_HDR2,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ hdl/matrix_chain_order_cost_core.sv @@
// Flow: dimensions load at one item per cycle while o_ready is high. After the
//   item with the last mark, every interval of length L (L = 2 .. n-1) passes
//   through header, issue and drain states in turn; short chains go straight to the result.
// Throughput: one chain at a time, bound by the single cost-table read pair per cycle.
// Reset: synchronous, active low; clears the state machine, counts and valids.
//   Memories are not cleared; every cost entry used is written before it is read.
// ----------------------------------------------------------------------------
// matrix_chain_order_cost_core
// Loads matrix dimensions into a memory and runs the interval dynamic program
// over a cost-table memory, reporting the minimum scalar multiplication count.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_order_cost_core #(
    parameter int MAX_DIMS  = 64,
    parameter int DIM_WIDTH = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [DIM_WIDTH-1:0]         i_dim,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [mcoc_pkg::COST_W-1:0]       o_min_cost,
    output logic [mcoc_pkg::CNT_W-1:0]        o_matrix_count,
    output logic [mcoc_pkg::STAT_W-1:0]       o_status
);
    import mcoc_pkg::*;

    localparam int IW  = $clog2(MAX_DIMS);
    localparam int LCW = $clog2(MAX_DIMS + 1);
    localparam int AW  = 2 * IW;
    localparam int PW1 = 2 * DIM_WIDTH;
    localparam int PW2 = 3 * DIM_WIDTH;

    // memories
    logic [DIM_WIDTH-1:0] r_dim_mem  [MAX_DIMS];
    logic [COST_W-1:0]    r_cost_mem [2**AW];

    t_state r_state, n_state;

    logic [LCW-1:0]       r_load_count;
    logic                 r_ovf;
    logic [IW-1:0]        r_i, r_j, r_k, r_nm1;
    logic [DIM_WIDTH-1:0] r_dra, r_drb, r_d_lo, r_d_hi;
    logic [COST_W-1:0]    r_ca, r_cb;

    // pipeline
    logic                 r_v1, r_v2, r_v3;
    logic                 r_f1, r_f2, r_f3;
    logic                 r_l1, r_l2, r_l3;
    logic [PW1-1:0]       r_p1;
    logic [PW2-1:0]       r_p2;
    logic [COST_W:0]      r_s1, r_s2;
    logic [COST_W-1:0]    r_best;

    logic [COST_W-1:0]    r_res_cost;
    logic [CNT_W-1:0]     r_res_cnt;
    logic [STAT_W-1:0]    r_res_stat;

    logic                 in_acc;
    logic                 room;
    logic [LCW-1:0]       n_dims;
    logic                 ovf_now;
    logic                 issue_last;
    logic                 ivl_done;
    logic                 chain_done;
    logic                 emit;
    logic [IW-1:0]        dim_addr_a;
    logic [COST_W+1:0]    t_sum;
    logic [COST_W-1:0]    t_sat;
    logic [COST_W-1:0]    best_new;

    assign in_acc     = i_valid && o_ready;
    assign room       = (r_load_count < LCW'(MAX_DIMS));
    assign n_dims     = room ? r_load_count + LCW'(1) : r_load_count;
    assign ovf_now    = r_ovf || !room;
    assign issue_last = (r_k + IW'(1) == r_j);
    assign ivl_done   = r_v3 && r_l3;
    assign chain_done = (r_i == IW'(1)) && (r_j == r_nm1);
    assign dim_addr_a = (r_state == S_HDR) ? r_i - IW'(1) : r_k;

    // final stage: add, saturate, keep the minimum
    assign t_sum    = {1'b0, r_s2} + (COST_W + 2)'(r_p2);
    assign t_sat    = (|t_sum[COST_W+1:COST_W]) ? COST_MAX : t_sum[COST_W-1:0];
    assign best_new = (r_f3 || t_sat < r_best) ? t_sat : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        emit    = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (in_acc && i_last) begin
                    n_state = (n_dims < LCW'(3)) ? S_EMIT : S_HDR;
                end
            end
            S_HDR:   n_state = S_HDR2;
            S_HDR2:  n_state = S_ISSUE;
            S_ISSUE: begin
                if (issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (ivl_done) begin
                    n_state = chain_done ? S_EMIT : S_HDR;
                end
            end
            S_EMIT: begin
                if (!o_valid || i_ready) begin
                    emit    = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // load and interval control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_ovf        <= 1'b0;
        end else if (in_acc) begin
            if (i_last) begin
                r_load_count <= '0;
                r_ovf        <= 1'b0;
            end else begin
                r_load_count <= n_dims;
                r_ovf        <= ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last) begin
            r_i        <= IW'(1);
            r_j        <= IW'(2);
            r_nm1      <= IW'(n_dims - LCW'(1));
            r_res_cost <= '0;
            r_res_cnt  <= CNT_W'(n_dims - LCW'(1));
            if (n_dims < LCW'(2)) begin
                r_res_stat <= ST_SHORT;
            end else begin
                r_res_stat <= ovf_now ? ST_TRUNC : ST_OK;
            end
        end
        if (r_state == S_HDR2) begin
            r_d_lo <= r_dra;
            r_d_hi <= r_drb;
            r_k    <= r_i;
        end else if (r_state == S_ISSUE) begin
            r_k <= r_k + IW'(1);
        end
        if (r_state == S_DRAIN && ivl_done) begin
            if (chain_done) begin
                r_res_cost <= best_new;
            end else if (r_j == r_nm1) begin
                r_i <= IW'(1);
                r_j <= (r_j - r_i) + IW'(2);
            end else begin
                r_i <= r_i + IW'(1);
                r_j <= r_j + IW'(1);
            end
        end
    end

    // dimension memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            r_dim_mem[r_load_count[IW-1:0]] <= i_dim;
        end
        r_dra <= r_dim_mem[dim_addr_a];
        r_drb <= r_dim_mem[r_j];
    end

    // cost table: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (ivl_done) begin
            r_cost_mem[{r_i, r_j}] <= best_new;
        end
        r_ca <= r_cost_mem[{r_i, r_k}];
        r_cb <= r_cost_mem[{r_k + IW'(1), r_j}];
    end

    // pipeline valids and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_ISSUE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= (r_k == r_i);
        r_l1 <= issue_last;
        r_f2 <= r_f1;
        r_l2 <= r_l1;
        r_f3 <= r_f2;
        r_l3 <= r_l2;
        // diagonal entries read as zero
        r_s1 <= {1'b0, (r_f1 ? '0 : r_ca)} + {1'b0, (r_l1 ? '0 : r_cb)};
        r_p1 <= PW1'(r_d_lo) * PW1'(r_dra);
        r_s2 <= r_s1;
        r_p2 <= PW2'(r_p1) * PW2'(r_d_hi);
        if (r_v3) begin
            r_best <= best_new;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_min_cost     <= r_res_cost;
            o_matrix_count <= r_res_cnt;
            o_status       <= r_res_stat;
        end
    end

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= LCW'(MAX_DIMS))
        else $error("load count beyond capacity");

    a_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !(r_v1 || r_v2 || r_v3))
        else $error("pipeline busy while loading");

    a_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ivl_done |-> (r_state == S_DRAIN))
        else $error("cost write outside drain");

    a_issue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_i <= r_k && r_k < r_j))
        else $error("split index out of interval");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_state == S_LOAD && o_valid))
        else $error("result not presented after emit");

endmodule

`default_nettype wire

@@ sim/matrix_chain_order_cost_core_tb.sv @@
// ----------------------------------------------------------------------------
// matrix_chain_order_cost_core_tb
// Streams matrix dimension chains into the core, predicts the least scalar
// multiplication count of each chain with an interval dynamic program of its
// own, and checks every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module matrix_chain_order_cost_core_tb;
    import mcoc_pkg::*;

    localparam int MAX_DIMS     = 64;
    localparam int DIM_W        = 12;
    localparam int TARGET_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [DIM_W-1:0] DIM_TOP = {DIM_W{1'b1}};

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic             last;
    } t_dim_item;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] status;
    } t_chain_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [DIM_W-1:0]  i_dim = '0;
    logic              i_last = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [COST_W-1:0] o_min_cost;
    logic [CNT_W-1:0]  o_matrix_count;
    logic [STAT_W-1:0] o_status;

    t_dim_item     pending_dims[$];
    t_chain_result expected_costs[$];
    t_dim_item     next_dim;
    t_chain_result oldest_cost;

    // predictor state: current chain and interval cost table
    logic [DIM_W-1:0]  chain_dims [0:MAX_DIMS-1];
    logic [COST_W-1:0] interval_cost [1:MAX_DIMS-1][1:MAX_DIMS-1];
    int                dims_kept = 0;
    logic              dims_dropped = 1'b0;

    int queued_items = 0;
    int items_accepted = 0;
    int chains_checked = 0;
    int short_chains = 0;
    int trunc_chains = 0;
    int errors = 0;
    int cycle_count = 0;

    matrix_chain_order_cost_core #(
        .MAX_DIMS  (MAX_DIMS),
        .DIM_WIDTH (DIM_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_dim          (i_dim),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_min_cost     (o_min_cost),
        .o_matrix_count (o_matrix_count),
        .o_status       (o_status)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // cost[i][j] = min over k of cost[i][k] + cost[k+1][j] + d[i-1]*d[k]*d[j]
    function automatic logic [COST_W-1:0] chain_min_cost(input int n);
        logic [COST_W-1:0] best;
        logic [COST_W-1:0] term;
        logic [COST_W+1:0] sum;
        int j;
        for (int i = 1; i < n; i++) interval_cost[i][i] = '0;
        for (int len = 2; len < n; len++) begin
            for (int i = 1; i + len - 1 < n; i++) begin
                j = i + len - 1;
                best = COST_MAX;
                for (int k = i; k < j; k++) begin
                    term = COST_W'(chain_dims[i-1]) * COST_W'(chain_dims[k])
                         * COST_W'(chain_dims[j]);
                    sum = {2'b00, interval_cost[i][k]} + {2'b00, interval_cost[k+1][j]}
                        + {2'b00, term};
                    if (sum > {2'b00, COST_MAX}) sum = {2'b00, COST_MAX};
                    if (k == i || sum[COST_W-1:0] < best) best = sum[COST_W-1:0];
                end
                interval_cost[i][j] = best;
            end
        end
        return interval_cost[1][n-1];
    endfunction

    task automatic take_dim(input logic [DIM_W-1:0] dim, input logic last);
        t_chain_result res;
        if (dims_kept < MAX_DIMS) begin
            chain_dims[dims_kept] = dim;
            dims_kept++;
        end else begin
            dims_dropped = 1'b1;
        end
        if (last) begin
            res.count = CNT_W'(dims_kept - 1);
            if (dims_kept < 2) begin
                res.cost   = '0;
                res.status = ST_SHORT;
                short_chains++;
            end else begin
                res.cost   = chain_min_cost(dims_kept);
                res.status = dims_dropped ? ST_TRUNC : ST_OK;
                if (dims_dropped) trunc_chains++;
            end
            expected_costs.push_back(res);
            dims_kept    = 0;
            dims_dropped = 1'b0;
        end
    endtask

    task automatic push_dim(input logic [DIM_W-1:0] dim, input logic last);
        t_dim_item it;
        it.dim  = dim;
        it.last = last;
        pending_dims.push_back(it);
        queued_items++;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        logic [DIM_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1, 2:    d = DIM_TOP;
            3, 4:    d = DIM_W'($urandom_range(1, 15));
            default: d = DIM_W'($urandom_range(0, 4095));
        endcase
        return d;
    endfunction

    // all_top: every dimension at its maximum
    task automatic push_chain(input int n, input bit all_top);
        for (int i = 0; i < n; i++)
            push_dim(all_top ? DIM_TOP : pick_dim(), i == n - 1);
    endtask

    // three traffic phases: receiver-heavy idling, sender-heavy idling, none
    function automatic int traffic_phase();
        return (queued_items == 0) ? 2 : (items_accepted * 3) / queued_items;
    endfunction

    function automatic int sender_idle_pct();
        case (traffic_phase())
            0:       return 26;
            1:       return 65;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (traffic_phase())
            0:       return 65;
            1:       return 26;
            default: return 0;
        endcase
    endfunction

    // driver: predict on acceptance, then present the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                take_dim(i_dim, i_last);
                items_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_dims.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    next_dim = pending_dims.pop_front();
                    i_valid <= 1'b1;
                    i_dim   <= next_dim.dim;
                    i_last  <= next_dim.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and in-order compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_costs.size() == 0) begin
                    $error("result with nothing expected: min_cost %0d count %0d status %0d",
                           o_min_cost, o_matrix_count, o_status);
                    errors++;
                end else begin
                    oldest_cost = expected_costs.pop_front();
                    chains_checked++;
                    if (o_min_cost !== oldest_cost.cost) begin
                        $error("min_cost: expected %0d, got %0d", oldest_cost.cost, o_min_cost);
                        errors++;
                    end
                    if (o_matrix_count !== oldest_cost.count) begin
                        $error("matrix_count: expected %0d, got %0d",
                               oldest_cost.count, o_matrix_count);
                        errors++;
                    end
                    if (o_status !== oldest_cost.status) begin
                        $error("status: expected %0d, got %0d", oldest_cost.status, o_status);
                        errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix_chain_order_cost_core: mismatch");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    initial begin
        int long_sizes[3];
        int long_idx;
        int long_left;

        // directed: single dimension, zeros, maxima, a textbook chain
        push_dim(DIM_TOP, 1'b1);
        push_dim('0, 1'b1);
        push_dim('0, 1'b0);
        push_dim(DIM_TOP, 1'b1);
        push_chain(3, 1'b1);
        push_dim(12'd10, 1'b0);
        push_dim(12'd30, 1'b0);
        push_dim(12'd5, 1'b0);
        push_dim(12'd60, 1'b1);
        push_dim(12'd0, 1'b0);
        push_dim(12'd1, 1'b0);
        push_dim(12'd2048, 1'b0);
        push_dim(DIM_TOP, 1'b0);
        push_dim(12'd1, 1'b1);
        push_dim(12'd7, 1'b0);
        push_dim('0, 1'b0);
        push_dim(12'd9, 1'b1);

        // random chains; a few long ones fill the store or spill past it
        long_sizes = '{MAX_DIMS, MAX_DIMS + 3, MAX_DIMS + $urandom_range(1, 6)};
        long_idx = 0;
        // long chains still to come count against the item budget
        long_left = long_sizes[0] + long_sizes[1] + long_sizes[2];
        while (queued_items + long_left < TARGET_ITEMS) begin
            if (long_idx < 3 && $urandom_range(0, 19) == 0) begin
                push_chain(long_sizes[long_idx], long_idx == 0);
                long_left -= long_sizes[long_idx];
                long_idx++;
            end else begin
                push_chain($urandom_range(1, 10), 1'b0);
            end
        end
        while (long_idx < 3) begin
            push_chain(long_sizes[long_idx], long_idx == 0);
            long_left -= long_sizes[long_idx];
            long_idx++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_dims.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d dimension items in %0d chains (%0d too short, %0d truncated)",
                 items_accepted, chains_checked, short_chains, trunc_chains);
        $display("traffic: sender and receiver idling in both orders, then full rate");
        if (errors == 0)
            $display("matrix_chain_order_cost_core: match");
        else
            $display("matrix_chain_order_cost_core: mismatch");
        $finish;
    end

endmodule
